// ----- hdl/tprm_pkg.sv -----
// Shared types and helpers for the touchpad to relative mouse block.
// Holds the scan and report beat structs and the delta scaling function.
// No dependencies.
`default_nettype none

package tprm_pkg;

    localparam int PosWidth   = 16;
    localparam int DeltaWidth = PosWidth + 1;
    localparam int MoveWidth  = 8;
    localparam int DeltaLimit = 127;

    typedef struct packed {
        logic [PosWidth-1:0] pos_x;
        logic [PosWidth-1:0] pos_y;
        logic                contact;
        logic                pad_pressed;
        logic                click_key;
        logic                ctrl_key;
        logic                shift_key;
    } scan_t;

    typedef struct packed {
        logic                        left_button;
        logic signed [MoveWidth-1:0] move_x;
        logic signed [MoveWidth-1:0] move_y;
    } report_t;

    // Halve with truncation toward zero, then saturate to +/-DeltaLimit.
    function automatic logic signed [MoveWidth-1:0] halve_clamp(
        input logic signed [DeltaWidth-1:0] d
    );
        logic signed [DeltaWidth-1:0] rounded;
        logic signed [DeltaWidth-1:0] half;
        rounded = d + DeltaWidth'(d[DeltaWidth-1]);
        half    = rounded >>> 1;
        if (half > DeltaWidth'(DeltaLimit))
            halve_clamp = MoveWidth'(DeltaLimit);
        else if (half < -DeltaWidth'(DeltaLimit))
            halve_clamp = -MoveWidth'(DeltaLimit);
        else
            halve_clamp = half[MoveWidth-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/touchpad_to_relative_mouse.sv -----
// A scan's report enters the report register as it advances. Throughput: one scan
// beat per cycle unless a report waits untaken; a scan matching the last sent
// report produces no beat. The report register decouples the two channels.
// Reset (rst_n, async, low): position history cleared, vertical flip on,
// last sent report zero, both channels empty.
// Top level: input register, tprm_motion, report register. Uses tprm_pkg.
`default_nettype none

module touchpad_to_relative_mouse (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              scan_valid,
    output logic                   scan_ready,
    input  wire tprm_pkg::scan_t   scan,
    output logic                   report_valid,
    input  wire logic              report_ready,
    output tprm_pkg::report_t      report
);

    logic              scan_valid_reg;
    tprm_pkg::scan_t   scan_reg;
    logic              report_valid_reg;
    tprm_pkg::report_t report_reg;

    tprm_pkg::report_t next_report;
    logic              emit;
    logic              advance;

    // advance when the result has somewhere to go, or there is no result
    assign advance    = scan_valid_reg & (~report_valid_reg | report_ready | ~emit);
    assign scan_ready = ~scan_valid_reg | advance;

    tprm_motion u_motion (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .scan    (scan_reg),
        .report  (next_report),
        .emit    (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg <= 1'b0;
        end
        else if (scan_ready)
        begin
            scan_valid_reg <= scan_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_ready && scan_valid)
        begin
            scan_reg <= scan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            report_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            report_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            report_reg <= next_report;
        end
    end

    assign report_valid = report_valid_reg;
    assign report       = report_reg;

`ifndef SYNTHESIS
    // an empty input register always takes a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !scan_valid_reg |-> scan_ready)
        else $error("input stage empty but not ready");
    // a held scan stays in place until it advances
    assert property (@(posedge clk) disable iff (!rst_n)
        scan_valid_reg && !advance |=> scan_valid_reg && $stable(scan_reg))
        else $error("held scan lost");
    // an emitted result lands in the report register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && emit |=> report_valid_reg && (report_reg == $past(next_report)))
        else $error("report not loaded");
    // never overwrite a report that was not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        report_valid_reg && !report_ready |-> !(advance && emit))
        else $error("report overwritten");
`endif

endmodule

`default_nettype wire

// ----- hdl/tprm_motion.sv -----
// Motion tracker: holds the previous position, flip and sent-report state,
// and forms the report for the scan in the input register. Uses tprm_pkg.
`default_nettype none

module tprm_motion (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire tprm_pkg::scan_t scan,
    output tprm_pkg::report_t    report,
    output logic                 emit
);

    logic [tprm_pkg::PosWidth-1:0] last_x_reg;
    logic [tprm_pkg::PosWidth-1:0] last_y_reg;
    logic                          have_last_reg;
    logic                          flip_reg;
    logic                          combo_held_reg;
    tprm_pkg::report_t             sent_reg;

    logic                                    button;
    logic                                    combo;
    logic                                    flip_next;
    logic                                    moving;
    logic signed [tprm_pkg::DeltaWidth-1:0]  dx;
    logic signed [tprm_pkg::DeltaWidth-1:0]  dy;
    logic signed [tprm_pkg::DeltaWidth-1:0]  dy_dir;

    always_comb
    begin
        button    = scan.pad_pressed | scan.click_key;
        combo     = scan.ctrl_key & scan.shift_key & button;
        // toggle on the rising edge of the combo; the new setting applies now
        flip_next = flip_reg ^ (combo & ~combo_held_reg);
        moving    = scan.contact & have_last_reg;
        dx        = $signed({1'b0, scan.pos_x}) - $signed({1'b0, last_x_reg});
        dy        = $signed({1'b0, scan.pos_y}) - $signed({1'b0, last_y_reg});
        dy_dir    = flip_next ? -dy : dy;
        report.left_button = button;
        report.move_x = moving ? tprm_pkg::halve_clamp(dx) : '0;
        report.move_y = moving ? tprm_pkg::halve_clamp(dy_dir) : '0;
        emit = (report != sent_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_x_reg     <= '0;
            last_y_reg     <= '0;
            have_last_reg  <= 1'b0;
            flip_reg       <= 1'b1;
            combo_held_reg <= 1'b0;
            sent_reg       <= '0;
        end
        else if (advance)
        begin
            flip_reg       <= flip_next;
            combo_held_reg <= combo;
            have_last_reg  <= scan.contact;
            sent_reg       <= report;
            if (scan.contact)
            begin
                last_x_reg <= scan.pos_x;
                last_y_reg <= scan.pos_y;
            end
        end
    end

`ifndef SYNTHESIS
    // a move never takes the unbalanced code
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (report.move_x != -8'sd128) && (report.move_y != -8'sd128))
        else $error("move out of range");
    // no contact means no movement
    assert property (@(posedge clk) disable iff (!rst_n)
        !scan.contact |-> (report.move_x == '0) && (report.move_y == '0))
        else $error("movement without contact");
    // after a scan advances, its report becomes the last sent, so it is not emitted again
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (sent_reg == $past(report)))
        else $error("sent report not tracked");
`endif

endmodule

`default_nettype wire
